// ===== hw/rtl/cubic_bezier_tessellator_assert.svh =====
// Assertion helpers for the tessellator top level.
// Both macros sample on the rising edge of clk and are disabled while arst_n is low.
`ifndef CUBIC_BEZIER_TESSELLATOR_ASSERT_SVH
`define CUBIC_BEZIER_TESSELLATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBT_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define CBT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/cbt_pkg.sv =====
package cbt_pkg;

	localparam int CoordW      = 16;
	localparam int CountW      = 6;
	localparam int MaxSegments = 63;
	localparam int FifoDepth   = 2;

	typedef logic signed [CoordW-1:0] coord_t;
	typedef logic [CountW-1:0]        count_t;

	localparam count_t SegCountReset = CountW'(32);
	localparam coord_t CoordMax      = {1'b0, {(CoordW-1){1'b1}}};
	localparam coord_t CoordMin      = {1'b1, {(CoordW-1){1'b0}}};

	typedef struct packed {
		coord_t start_x;
		coord_t start_y;
		coord_t start_handle_dx;
		coord_t start_handle_dy;
		coord_t end_x;
		coord_t end_y;
		coord_t end_handle_dx;
		coord_t end_handle_dy;
		logic   endpoint_only;
	} item_t;

	typedef struct packed {
		coord_t point_x;
		coord_t point_y;
		logic   last_point;
	} point_t;

	// One queued segment: control points P0..P3 (index 0 is P0) and its piece count.
	typedef struct packed {
		coord_t [3:0] px;
		coord_t [3:0] py;
		count_t       n;
		logic         eop;
	} entry_t;

	typedef struct packed {
		logic   issue;
		logic   pop;
		count_t step;
	} seq_status_t;

endpackage

// ===== hw/rtl/cbt_front.sv =====
module cbt_front import cbt_pkg::*; #(
	parameter int MAX_SEGMENTS = MaxSegments
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_wen,
	input  count_t cfg_wdata,
	input  item_t  item,
	output entry_t entry
);

	count_t seg_count_q;
	count_t n_clamped;

	function automatic coord_t sat_add(coord_t a, coord_t b);
		logic [CoordW:0] s;
		s = {a[CoordW-1], a} + {b[CoordW-1], b};
		if (s[CoordW] != s[CoordW-1]) begin
			return s[CoordW] ? CoordMin : CoordMax;
		end
		return s[CoordW-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= SegCountReset;
		end else if (cfg_wen) begin
			seg_count_q <= cfg_wdata;
		end
	end

	always_comb begin
		if (seg_count_q == '0) begin
			n_clamped = CountW'(1);
		end else if (seg_count_q > CountW'(MAX_SEGMENTS)) begin
			n_clamped = CountW'(MAX_SEGMENTS);
		end else begin
			n_clamped = seg_count_q;
		end
	end

	// A start-point-only item runs as a one-piece curve evaluated at its first step only.
	always_comb begin
		entry.px[0] = item.start_x;
		entry.py[0] = item.start_y;
		entry.px[1] = sat_add(item.start_x, item.start_handle_dx);
		entry.py[1] = sat_add(item.start_y, item.start_handle_dy);
		entry.px[2] = sat_add(item.end_x, item.end_handle_dx);
		entry.py[2] = sat_add(item.end_y, item.end_handle_dy);
		entry.px[3] = item.end_x;
		entry.py[3] = item.end_y;
		entry.eop   = item.endpoint_only;
		entry.n     = item.endpoint_only ? CountW'(1) : n_clamped;
	end

endmodule

// ===== hw/rtl/cbt_fifo.sv =====
module cbt_fifo import cbt_pkg::*; #(
	parameter int DEPTH = FifoDepth
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr_entry,
	input  logic   pop,
	output logic   full,
	output logic   head_valid,
	output entry_t head
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	entry_t            mem_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full       = (count_q == CntW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/cbt_eval.sv =====
module cbt_eval import cbt_pkg::*; #(
	parameter int MAX_SEGMENTS = MaxSegments,
	localparam int CubeW = $clog2(MAX_SEGMENTS ** 3 + 1),
	localparam int NumW  = CubeW + CoordW + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   head_valid,
	input  entry_t                 head,
	output seq_status_t            status,
	output logic                   out_valid,
	output logic                   out_last,
	output logic signed [NumW-1:0] num_x,
	output logic signed [NumW-1:0] num_y,
	output logic [CubeW-1:0]       den
);

	localparam int MulW = 3 * CountW + 2;
	localparam int SqW  = 2 * CountW;

	count_t k_q;
	logic   issue;
	logic   last_issue;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic last_s1, last_s2, last_s3, last_s4, last_s5;

	count_t                k_s1, m_s1, n_s1;
	count_t                k_s2, m_s2, n_s2;
	logic [2*CountW-1:0]   m2_s2, k2_s2, n2_s2;
	coord_t [3:0]          px_s1, py_s1, px_s2, py_s2, px_s3, py_s3;
	logic [CubeW-1:0]      coef_s3 [4];
	logic [CubeW-1:0]      den_s3, den_s4, den_s5;
	logic signed [NumW-1:0] prod_x_s4 [4];
	logic signed [NumW-1:0] prod_y_s4 [4];
	logic signed [NumW-1:0] num_x_s5, num_y_s5;

	logic [MulW-1:0] term [4];
	logic [MulW-1:0] den_term;

	assign issue      = head_valid && adv;
	assign last_issue = head.eop || (k_q == head.n);

	assign status.issue = issue;
	assign status.pop   = issue && last_issue;
	assign status.step  = k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			if (issue) begin
				k_q <= last_issue ? '0 : k_q + 1'b1;
			end
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Bernstein weights scaled by N^3: m^3, 3m^2k, 3mk^2 and k^3 with m = N - k.
	always_comb begin
		term[0]  = MulW'(m2_s2) * MulW'(m_s2);
		term[1]  = MulW'(m2_s2) * MulW'(k_s2) * MulW'(3);
		term[2]  = MulW'(k2_s2) * MulW'(m_s2) * MulW'(3);
		term[3]  = MulW'(k2_s2) * MulW'(k_s2);
		den_term = MulW'(n2_s2) * MulW'(n_s2);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			k_s1    <= k_q;
			m_s1    <= head.n - k_q;
			n_s1    <= head.n;
			px_s1   <= head.px;
			py_s1   <= head.py;
			last_s1 <= last_issue;

			m2_s2   <= SqW'(m_s1) * SqW'(m_s1);
			k2_s2   <= SqW'(k_s1) * SqW'(k_s1);
			n2_s2   <= SqW'(n_s1) * SqW'(n_s1);
			m_s2    <= m_s1;
			k_s2    <= k_s1;
			n_s2    <= n_s1;
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			last_s2 <= last_s1;

			for (int i = 0; i < 4; i++) begin
				coef_s3[i] <= term[i][CubeW-1:0];
			end
			den_s3  <= den_term[CubeW-1:0];
			px_s3   <= px_s2;
			py_s3   <= py_s2;
			last_s3 <= last_s2;

			for (int i = 0; i < 4; i++) begin
				prod_x_s4[i] <= NumW'($signed({1'b0, coef_s3[i]})) * NumW'(px_s3[i]);
				prod_y_s4[i] <= NumW'($signed({1'b0, coef_s3[i]})) * NumW'(py_s3[i]);
			end
			den_s4  <= den_s3;
			last_s4 <= last_s3;

			num_x_s5 <= prod_x_s4[0] + prod_x_s4[1] + prod_x_s4[2] + prod_x_s4[3];
			num_y_s5 <= prod_y_s4[0] + prod_y_s4[1] + prod_y_s4[2] + prod_y_s4[3];
			den_s5   <= den_s4;
			last_s5  <= last_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_last  = last_s5;
	assign num_x     = num_x_s5;
	assign num_y     = num_y_s5;
	assign den       = den_s5;

endmodule

// ===== hw/rtl/cbt_div.sv =====
module cbt_div import cbt_pkg::*; #(
	parameter int MAX_SEGMENTS = MaxSegments,
	localparam int CubeW = $clog2(MAX_SEGMENTS ** 3 + 1),
	localparam int NumW  = CubeW + CoordW + 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  logic                   in_valid,
	input  logic                   in_last,
	input  logic signed [NumW-1:0] num_x,
	input  logic signed [NumW-1:0] num_y,
	input  logic [CubeW-1:0]       den,
	output logic                   out_valid,
	output point_t                 out_point
);

	localparam int AW = NumW + 1;
	localparam int BW = CubeW + 1;
	localparam int QW = CoordW;

	logic [NumW-1:0] mag_x, mag_y;

	logic            v_s      [QW+1];
	logic            last_s   [QW+1];
	logic            sign_x_s [QW+1];
	logic            sign_y_s [QW+1];
	logic [BW-1:0]   b_s      [QW+1];
	logic [AW-1:0]   rem_x_s  [QW+1];
	logic [AW-1:0]   rem_y_s  [QW+1];
	logic [QW-1:0]   q_x_s    [QW+1];
	logic [QW-1:0]   q_y_s    [QW+1];

	assign mag_x = num_x[NumW-1] ? (~num_x + 1'b1) : num_x;
	assign mag_y = num_y[NumW-1] ? (~num_y + 1'b1) : num_y;

	// Rounding to nearest with ties away from zero is floor((2|num| + D) / 2D).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			last_s[0]   <= in_last;
			sign_x_s[0] <= num_x[NumW-1];
			sign_y_s[0] <= num_y[NumW-1];
			b_s[0]      <= {den, 1'b0};
			rem_x_s[0]  <= {mag_x, 1'b0} + AW'(den);
			rem_y_s[0]  <= {mag_y, 1'b0} + AW'(den);
			q_x_s[0]    <= '0;
			q_y_s[0]    <= '0;
		end
	end

	// One quotient bit per stage, most significant first.
	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int Bit = QW - 1 - j;

		logic [AW-1:0] shifted;
		logic          ge_x, ge_y;

		assign shifted = AW'(b_s[j]) << Bit;
		assign ge_x    = (rem_x_s[j] >= shifted);
		assign ge_y    = (rem_y_s[j] >= shifted);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (adv) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				last_s[j+1]   <= last_s[j];
				sign_x_s[j+1] <= sign_x_s[j];
				sign_y_s[j+1] <= sign_y_s[j];
				b_s[j+1]      <= b_s[j];
				rem_x_s[j+1]  <= ge_x ? rem_x_s[j] - shifted : rem_x_s[j];
				rem_y_s[j+1]  <= ge_y ? rem_y_s[j] - shifted : rem_y_s[j];
				q_x_s[j+1]    <= q_x_s[j] | (QW'(ge_x) << Bit);
				q_y_s[j+1]    <= q_y_s[j] | (QW'(ge_y) << Bit);
			end
		end
	end

	assign out_valid            = v_s[QW];
	assign out_point.last_point = last_s[QW];
	assign out_point.point_x    = sign_x_s[QW] ? (~q_x_s[QW] + 1'b1) : q_x_s[QW];
	assign out_point.point_y    = sign_y_s[QW] ? (~q_y_s[QW] + 1'b1) : q_y_s[QW];

endmodule

// ===== hw/rtl/cubic_bezier_tessellator.sv =====
// Cubic Bezier tessellator.
// Segments arrive on the item channel (valid/ready): two nodes, two handle offsets and an
// endpoint_only flag. Points leave on the point channel (valid/ready), N+1 per segment at
// t = k/N, with last_point set on the final one; an endpoint_only segment gives the start
// node alone. N comes from the segment count register; the user must write it through
// cfg_wen/cfg_wdata only while the block is idle, which it does not enforce; zero
// counts as one and values above MAX_SEGMENTS are clamped. Throughput: one point per
// cycle while the receiver accepts and segments are queued; the step sequencer feeds the
// evaluation pipeline one step index per cycle while it advances. The first point of a
// segment passes from the queue through five stages of weight and product arithmetic, one
// set-up stage and sixteen restoring divider stages, then the output register.
// A queue of FIFO_DEPTH segments sits between the input side and the sequencer, so new
// segments are taken while earlier ones are still being evaluated.
// When the receiver stalls, the whole evaluation pipeline holds; nothing is lost or dropped.
// Reset clears the queue, the sequencer, all stage valid flags and the output valid flag, and
// sets the segment count to 32.
`include "cubic_bezier_tessellator_assert.svh"

module cubic_bezier_tessellator import cbt_pkg::*; #(
	parameter int MAX_SEGMENTS = MaxSegments,
	parameter int FIFO_DEPTH   = FifoDepth
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_wen,
	input  count_t cfg_wdata,
	input  logic   item_valid,
	output logic   item_ready,
	input  item_t  item,
	output logic   point_valid,
	input  logic   point_ready,
	output point_t point
);

	localparam int CubeW = $clog2(MAX_SEGMENTS ** 3 + 1);
	localparam int NumW  = CubeW + CoordW + 1;

	entry_t      new_entry;
	entry_t      head;
	logic        head_valid;
	logic        full;
	logic        adv;
	seq_status_t seq_status;

	logic                   eval_valid, eval_last;
	logic signed [NumW-1:0] num_x, num_y;
	logic [CubeW-1:0]       den;

	logic   div_valid;
	point_t div_point;

	logic   point_valid_q;
	point_t point_q;

	// The pipeline moves whenever the output register is empty or being emptied.
	assign adv        = !point_valid_q || point_ready;
	assign item_ready = !full;

	cbt_front #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.item     (item),
		.entry    (new_entry)
	);

	cbt_fifo #(
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (item_valid && item_ready),
		.wr_entry  (new_entry),
		.pop       (seq_status.pop),
		.full      (full),
		.head_valid(head_valid),
		.head      (head)
	);

	cbt_eval #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.head_valid(head_valid),
		.head      (head),
		.status    (seq_status),
		.out_valid (eval_valid),
		.out_last  (eval_last),
		.num_x     (num_x),
		.num_y     (num_y),
		.den       (den)
	);

	cbt_div #(
		.MAX_SEGMENTS(MAX_SEGMENTS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (eval_valid),
		.in_last  (eval_last),
		.num_x    (num_x),
		.num_y    (num_y),
		.den      (den),
		.out_valid(div_valid),
		.out_point(div_point)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_valid_q <= 1'b0;
		end else if (adv) begin
			point_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			point_q <= div_point;
		end
	end

	assign point_valid = point_valid_q;
	assign point       = point_q;

	`CBT_ASSERT_IMPLY(a_issue_has_head, seq_status.issue, head_valid)
	`CBT_ASSERT_IMPLY(a_step_in_range, head_valid, seq_status.step <= head.n)
	`CBT_ASSERT_IMPLY(a_single_point_pops, seq_status.issue && head.eop, seq_status.pop)
	`CBT_ASSERT_NEXT(a_step_restarts, seq_status.pop, seq_status.step == '0)

endmodule
